>>> rtl/qau_pkg.sv
// Shared types, widths and arithmetic helpers of the quaternion arithmetic unit.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

    localparam int DW      = 32;             // data word
    localparam int FRAC    = 16;             // fraction bits
    localparam int LANES   = 4;              // quaternion components / matrix columns
    localparam int ROWS    = 4;              // matrix rows
    localparam int SUM_W   = 2 * DW + 2;     // exact sums of four products
    localparam int SQ_W    = 2 * DW + 1;     // sum of four squares
    localparam int ROOT_W  = DW + 1;         // floor square root of that sum
    localparam int RAD_W   = 2 * ROOT_W;     // radicand padded to whole digit pairs
    localparam int N2_W    = SQ_W - FRAC;    // squared norm, unsigned
    localparam int NUM_W   = DW + FRAC;      // dividend magnitude
    localparam int DEN_W   = N2_W;           // divisor magnitude

    localparam logic signed [SUM_W-1:0] ONE_W = {{(SUM_W-1){1'b0}}, 1'b1} << FRAC;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_SCALE  = 4'd3,
        OP_DIV    = 4'd4,
        OP_CONJ   = 4'd5,
        OP_INV    = 4'd6,
        OP_NORMZ  = 4'd7,
        OP_NORM   = 4'd8,
        OP_MATRIX = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]    op;
        logic [DW-1:0] a_real;
        logic [DW-1:0] a_i;
        logic [DW-1:0] a_j;
        logic [DW-1:0] a_k;
        logic [DW-1:0] b_real;
        logic [DW-1:0] b_i;
        logic [DW-1:0] b_j;
        logic [DW-1:0] b_k;
        logic [DW-1:0] scalar;
        logic          norm_squared_select;
    } in_item_t;

    typedef struct packed {
        logic [DW-1:0] res_real;
        logic [DW-1:0] res_i;
        logic [DW-1:0] res_j;
        logic [DW-1:0] res_k;
        logic [1:0]    row_index;
        logic          last;
        logic [1:0]    status;
    } out_item_t;

    // Sideband carried alongside the square root pipeline
    typedef struct packed {
        op_t                      op;
        logic                     sel;
        logic [LANES-1:0][DW-1:0] a;
        logic [DW-1:0]            scalar;
        logic [N2_W-1:0]          n2;
        logic [LANES-1:0][DW-1:0] res;
        logic                     ovf;
    } sq_side_t;

    // Sideband carried alongside the divider pipeline
    typedef struct packed {
        op_t                      op;
        logic [LANES-1:0][DW-1:0] res;
        logic                     ovf;
        logic                     dz;
        logic [LANES-1:0]         neg;
    } dv_side_t;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          ovf;
    } sat_t;

    // Clamp an exact value to the data word
    function automatic sat_t sat_w(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (&v[SUM_W-1:DW-1] || ~|v[SUM_W-1:DW-1])
        begin
            r.val = v[DW-1:0];
            r.ovf = 1'b0;
        end
        else
        begin
            r.val = v[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Floor of a signed sum of four products, brought back to FRAC fraction bits
    function automatic logic signed [SUM_W-1:0] fsum(
        input logic signed [2*DW-1:0] p0,
        input logic signed [2*DW-1:0] p1,
        input logic signed [2*DW-1:0] p2,
        input logic signed [2*DW-1:0] p3,
        input logic [3:0]             sub
    );
        logic signed [SUM_W-1:0] e0;
        logic signed [SUM_W-1:0] e1;
        logic signed [SUM_W-1:0] e2;
        logic signed [SUM_W-1:0] e3;
        e0 = sub[0] ? -SUM_W'(p0) : SUM_W'(p0);
        e1 = sub[1] ? -SUM_W'(p1) : SUM_W'(p1);
        e2 = sub[2] ? -SUM_W'(p2) : SUM_W'(p2);
        e3 = sub[3] ? -SUM_W'(p3) : SUM_W'(p3);
        return (e0 + e1 + e2 + e3) >>> FRAC;
    endfunction

endpackage

`default_nettype wire

>>> rtl/qau_sqrt.sv
// Pipelined floor square root, one result bit per stage, with sideband.
// Depends on qau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qau_sqrt import qau_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  rad,
    input  wire sq_side_t          side_in,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output sq_side_t               side_out
);

    localparam int STAGES = ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    logic              valid_reg [STAGES];
    logic [RAD_W-1:0]  rad_reg   [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [ROOT_W-1:0] root_reg  [STAGES];
    sq_side_t          side_reg  [STAGES];

    logic [RAD_W-1:0]  rad_p     [STAGES];
    logic [REM_W-1:0]  rem_p     [STAGES];
    logic [ROOT_W-1:0] root_p    [STAGES];
    logic [REM_W-1:0]  rem_sh    [STAGES];
    logic [REM_W-1:0]  trial     [STAGES];
    logic [RAD_W-1:0]  rad_next  [STAGES];
    logic [REM_W-1:0]  rem_next  [STAGES];
    logic [ROOT_W-1:0] root_next [STAGES];

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                rad_p[k]  = rad;
                rem_p[k]  = '0;
                root_p[k] = '0;
            end
            else
            begin
                rad_p[k]  = rad_reg[k-1];
                rem_p[k]  = rem_reg[k-1];
                root_p[k] = root_reg[k-1];
            end
            // bring down the next digit pair and try root*4+1
            rem_sh[k]  = {rem_p[k][REM_W-3:0], rad_p[k][RAD_W-1 -: 2]};
            trial[k]   = {{(REM_W-ROOT_W-2){1'b0}}, root_p[k], 2'b01};
            rad_next[k] = {rad_p[k][RAD_W-3:0], 2'b00};
            if (rem_sh[k] >= trial[k])
            begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_p[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_p[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k < STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/qau_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
// Depends on qau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qau_div import qau_pkg::*; (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]            den,
    input  wire dv_side_t                    side_in,
    output logic                             out_valid,
    output logic [LANES-1:0][NUM_W-1:0]      quo,
    output dv_side_t                         side_out
);

    localparam int STAGES = NUM_W;
    localparam int REM_W  = DEN_W + 1;

    logic                        valid_reg [STAGES];
    logic [LANES-1:0][NUM_W-1:0] num_reg   [STAGES];
    logic [LANES-1:0][DEN_W-1:0] rem_reg   [STAGES];
    logic [LANES-1:0][NUM_W-1:0] quo_reg   [STAGES];
    logic [DEN_W-1:0]            den_reg   [STAGES];
    dv_side_t                    side_reg  [STAGES];

    logic [LANES-1:0][NUM_W-1:0] num_p     [STAGES];
    logic [LANES-1:0][DEN_W-1:0] rem_p     [STAGES];
    logic [LANES-1:0][NUM_W-1:0] quo_p     [STAGES];
    logic [DEN_W-1:0]            den_p     [STAGES];
    logic [LANES-1:0][REM_W-1:0] rem_sh    [STAGES];
    logic [LANES-1:0][NUM_W-1:0] num_next  [STAGES];
    logic [LANES-1:0][DEN_W-1:0] rem_next  [STAGES];
    logic [LANES-1:0][NUM_W-1:0] quo_next  [STAGES];

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                num_p[k] = num;
                rem_p[k] = '0;
                quo_p[k] = '0;
                den_p[k] = den;
            end
            else
            begin
                num_p[k] = num_reg[k-1];
                rem_p[k] = rem_reg[k-1];
                quo_p[k] = quo_reg[k-1];
                den_p[k] = den_reg[k-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                rem_sh[k][l]   = {rem_p[k][l], num_p[k][l][NUM_W-1]};
                num_next[k][l] = {num_p[k][l][NUM_W-2:0], 1'b0};
                if (rem_sh[k][l] >= {1'b0, den_p[k]})
                begin
                    rem_next[k][l] = DEN_W'(rem_sh[k][l] - {1'b0, den_p[k]});
                    quo_next[k][l] = {quo_p[k][l][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = rem_sh[k][l][DEN_W-1:0];
                    quo_next[k][l] = {quo_p[k][l][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_p[k];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k < STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit, top level: Q16.16 add/sub/product/scale/divide/
// conjugate/inverse/normalize/norm and rotation matrix. Depends on qau_pkg,
// qau_sqrt and qau_div.
// Every op takes the same path from the accepting edge to the first result strobe
// (3 front stages, 33 square-root stages, 48 divider stages, 3 back stages).
// Throughput: one item per cycle, except that a matrix item holds the whole pipeline
// (busy high) while its four rows go out. The receiver cannot stall.
// Reset clears all valid bits and the row counter; no result follows reset.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit import qau_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  operand,
    output logic           done,
    output out_item_t      result
);

    localparam logic [1:0] ROW_LAST = 2'(ROWS - 1);

    // matrix product slots
    localparam int PM_YY = 0;
    localparam int PM_ZZ = 1;
    localparam int PM_XY = 2;
    localparam int PM_ZW = 3;
    localparam int PM_XZ = 4;
    localparam int PM_YW = 5;
    localparam int PM_XX = 6;
    localparam int PM_YZ = 7;
    localparam int PM_XW = 8;
    localparam int NPM   = 9;

    logic en;

    // ---------------- front stage 0: capture ----------------
    logic     p0_valid_reg;
    in_item_t p0_reg;

    // ---------------- stage 1: products ----------------
    logic                    p1_valid_reg;
    op_t                     p1_op_reg;
    logic                    p1_sel_reg;
    logic signed [DW-1:0]    p1_a_reg   [LANES];
    logic signed [DW-1:0]    p1_b_reg   [LANES];
    logic [DW-1:0]           p1_scalar_reg;
    logic signed [2*DW-1:0]  p1_pab_reg [LANES][LANES];
    logic signed [2*DW-1:0]  p1_pas_reg [LANES];
    logic signed [2*DW-1:0]  p1_psq_reg [LANES];

    logic signed [DW-1:0]    a0 [LANES];
    logic signed [DW-1:0]    b0 [LANES];
    logic signed [2*DW-1:0]  pab_next [LANES][LANES];
    logic signed [2*DW-1:0]  pas_next [LANES];
    logic signed [2*DW-1:0]  psq_next [LANES];

    // ---------------- stage 2: sums and direct results ----------------
    logic            p2_valid_reg;
    sq_side_t        p2_side_reg;
    logic [SQ_W-1:0] p2_s_reg;

    sat_t            lane_sat [LANES];
    sq_side_t        p2_side_next;
    logic [SQ_W-1:0] s_next;
    sat_t            n2_sat;

    // ---------------- square root and divider ----------------
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    logic [LANES-1:0][NUM_W-1:0] dv_num;
    logic [DEN_W-1:0]            dv_den;
    dv_side_t                    dv_side_in;
    logic [DW-1:0]               a_mag [LANES];
    logic [DW-1:0]               s_mag;
    sat_t                        root_sat;

    logic                        dv_valid;
    logic [LANES-1:0][NUM_W-1:0] dv_quo;
    dv_side_t                    dv_side;

    // ---------------- stage 4: quotients ----------------
    logic          p4_valid_reg;
    op_t           p4_op_reg;
    logic [DW-1:0] p4_fin_reg [LANES];
    status_t       p4_st_reg;

    sat_t          q_sat [LANES];
    logic          q_ovf;
    logic [DW-1:0] fin_next [LANES];
    status_t       st_next;

    // ---------------- stage 5: matrix products ----------------
    logic                   p5_valid_reg;
    op_t                    p5_op_reg;
    logic [DW-1:0]          p5_fin_reg [LANES];
    status_t                p5_st_reg;
    logic signed [2*DW-1:0] p5_pm_reg  [NPM];

    logic signed [DW-1:0]   uw;
    logic signed [DW-1:0]   ux;
    logic signed [DW-1:0]   uy;
    logic signed [DW-1:0]   uz;
    logic signed [2*DW-1:0] pm_next [NPM];

    // ---------------- final stage: output rows ----------------
    logic          f_valid_reg;
    logic          f_mat_reg;
    logic [DW-1:0] f_rows_reg [ROWS][LANES];
    status_t       f_st_reg;
    logic [1:0]    cnt_reg;

    sat_t          ent [ROWS-1][ROWS-1];
    logic          m_ovf;
    logic [DW-1:0] rows_next [ROWS][LANES];
    status_t       f_st_next;

    // hold everything while a matrix item still has rows to send
    assign en   = !(f_valid_reg && f_mat_reg && cnt_reg != ROW_LAST);
    assign busy = !en;

    // ================= stage 0 =================
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else if (en)
            p0_valid_reg <= start && (operand.op inside {[OP_ADD:OP_MATRIX]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p0_reg <= operand;
    end

    // ================= stage 1 =================
    always_comb
    begin
        a0[0] = p0_reg.a_real;
        a0[1] = p0_reg.a_i;
        a0[2] = p0_reg.a_j;
        a0[3] = p0_reg.a_k;
        b0[0] = p0_reg.b_real;
        b0[1] = p0_reg.b_i;
        b0[2] = p0_reg.b_j;
        b0[3] = p0_reg.b_k;
        for (int i = 0; i < LANES; i++)
        begin
            for (int j = 0; j < LANES; j++)
                pab_next[i][j] = a0[i] * b0[j];
            pas_next[i] = a0[i] * $signed(p0_reg.scalar);
            psq_next[i] = a0[i] * a0[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= p0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_op_reg     <= op_t'(p0_reg.op);
            p1_sel_reg    <= p0_reg.norm_squared_select;
            p1_scalar_reg <= p0_reg.scalar;
            for (int i = 0; i < LANES; i++)
            begin
                p1_a_reg[i]   <= a0[i];
                p1_b_reg[i]   <= b0[i];
                p1_pas_reg[i] <= pas_next[i];
                p1_psq_reg[i] <= psq_next[i];
                for (int j = 0; j < LANES; j++)
                    p1_pab_reg[i][j] <= pab_next[i][j];
            end
        end
    end

    // ================= stage 2 =================
    always_comb
    begin
        s_next = SQ_W'(p1_psq_reg[0]) + SQ_W'(p1_psq_reg[1])
               + SQ_W'(p1_psq_reg[2]) + SQ_W'(p1_psq_reg[3]);
        n2_sat = sat_w($signed(SUM_W'(s_next[SQ_W-1:FRAC])));
        for (int i = 0; i < LANES; i++)
            lane_sat[i] = '0;
        case (p1_op_reg)
            OP_ADD:
                for (int i = 0; i < LANES; i++)
                    lane_sat[i] = sat_w(SUM_W'(p1_a_reg[i]) + SUM_W'(p1_b_reg[i]));
            OP_SUB:
                for (int i = 0; i < LANES; i++)
                    lane_sat[i] = sat_w(SUM_W'(p1_a_reg[i]) - SUM_W'(p1_b_reg[i]));
            OP_MUL:
            begin
                lane_sat[0] = sat_w(fsum(p1_pab_reg[0][0], p1_pab_reg[1][1],
                                         p1_pab_reg[2][2], p1_pab_reg[3][3], 4'b1110));
                lane_sat[1] = sat_w(fsum(p1_pab_reg[0][1], p1_pab_reg[1][0],
                                         p1_pab_reg[2][3], p1_pab_reg[3][2], 4'b1000));
                lane_sat[2] = sat_w(fsum(p1_pab_reg[0][2], p1_pab_reg[2][0],
                                         p1_pab_reg[3][1], p1_pab_reg[1][3], 4'b1000));
                lane_sat[3] = sat_w(fsum(p1_pab_reg[0][3], p1_pab_reg[3][0],
                                         p1_pab_reg[1][2], p1_pab_reg[2][1], 4'b1000));
            end
            OP_SCALE:
                for (int i = 0; i < LANES; i++)
                    lane_sat[i] = sat_w(fsum(p1_pas_reg[i], '0, '0, '0, 4'b0000));
            OP_CONJ:
            begin
                lane_sat[0] = sat_w(SUM_W'(p1_a_reg[0]));
                for (int i = 1; i < LANES; i++)
                    lane_sat[i] = sat_w(-SUM_W'(p1_a_reg[i]));
            end
            OP_NORM:
                if (p1_sel_reg)
                    lane_sat[0] = n2_sat;
            default:
                ;
        endcase

        p2_side_next.op     = p1_op_reg;
        p2_side_next.sel    = p1_sel_reg;
        p2_side_next.scalar = p1_scalar_reg;
        p2_side_next.n2     = s_next[SQ_W-1:FRAC];
        p2_side_next.ovf    = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            p2_side_next.a[i]   = p1_a_reg[i];
            p2_side_next.res[i] = lane_sat[i].val;
            p2_side_next.ovf    = p2_side_next.ovf | lane_sat[i].ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_side_reg <= p2_side_next;
            p2_s_reg    <= s_next;
        end
    end

    // ================= square root =================
    qau_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .rad       ({1'b0, p2_s_reg}),
        .side_in   (p2_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ================= divider operands =================
    always_comb
    begin
        s_mag    = sq_side.scalar[DW-1] ? DW'(-sq_side.scalar) : sq_side.scalar;
        root_sat = sat_w($signed(SUM_W'(sq_root)));
        dv_side_in.op  = sq_side.op;
        dv_side_in.res = sq_side.res;
        dv_side_in.ovf = sq_side.ovf;
        dv_side_in.dz  = 1'b0;
        dv_den         = DEN_W'(1);
        case (sq_side.op)
            OP_DIV:
            begin
                dv_den        = DEN_W'(s_mag);
                dv_side_in.dz = (sq_side.scalar == '0);
            end
            OP_INV:
            begin
                dv_den        = sq_side.n2;
                dv_side_in.dz = (sq_side.n2 == '0);
            end
            OP_NORMZ, OP_MATRIX:
            begin
                dv_den        = DEN_W'(sq_root);
                dv_side_in.dz = (sq_root == '0);
            end
            OP_NORM:
                if (!sq_side.sel)
                begin
                    dv_side_in.res    = '0;
                    dv_side_in.res[0] = root_sat.val;
                    dv_side_in.ovf    = root_sat.ovf;
                end
            default:
                ;
        endcase
        for (int i = 0; i < LANES; i++)
        begin
            a_mag[i]  = sq_side.a[i][DW-1] ? DW'(-sq_side.a[i]) : sq_side.a[i];
            dv_num[i] = {a_mag[i], {FRAC{1'b0}}};
            // quotient truncates toward zero, so work on magnitudes and fix the sign after
            dv_side_in.neg[i] = sq_side.a[i][DW-1]
                              ^ (sq_side.op == OP_DIV && sq_side.scalar[DW-1])
                              ^ (sq_side.op == OP_INV && i != 0);
        end
    end

    qau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (dv_num),
        .den       (dv_den),
        .side_in   (dv_side_in),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    // ================= stage 4 =================
    always_comb
    begin
        q_ovf = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            q_sat[i] = sat_w(dv_side.neg[i] ? -$signed(SUM_W'(dv_quo[i]))
                                            : $signed(SUM_W'(dv_quo[i])));
            q_ovf    = q_ovf | q_sat[i].ovf;
        end
        case (dv_side.op)
            OP_DIV, OP_INV, OP_NORMZ, OP_MATRIX:
            begin
                for (int i = 0; i < LANES; i++)
                    fin_next[i] = dv_side.dz ? '0 : q_sat[i].val;
                st_next = dv_side.dz ? ST_DZ : (q_ovf ? ST_SAT : ST_OK);
            end
            default:
            begin
                for (int i = 0; i < LANES; i++)
                    fin_next[i] = dv_side.res[i];
                st_next = dv_side.ovf ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else if (en)
            p4_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_op_reg <= dv_side.op;
            p4_st_reg <= st_next;
            for (int i = 0; i < LANES; i++)
                p4_fin_reg[i] <= fin_next[i];
        end
    end

    // ================= stage 5 =================
    always_comb
    begin
        uw = p4_fin_reg[0];
        ux = p4_fin_reg[1];
        uy = p4_fin_reg[2];
        uz = p4_fin_reg[3];
        pm_next[PM_YY] = uy * uy;
        pm_next[PM_ZZ] = uz * uz;
        pm_next[PM_XY] = ux * uy;
        pm_next[PM_ZW] = uz * uw;
        pm_next[PM_XZ] = ux * uz;
        pm_next[PM_YW] = uy * uw;
        pm_next[PM_XX] = ux * ux;
        pm_next[PM_YZ] = uy * uz;
        pm_next[PM_XW] = ux * uw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_valid_reg <= 1'b0;
        else if (en)
            p5_valid_reg <= p4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_op_reg <= p4_op_reg;
            p5_st_reg <= p4_st_reg;
            for (int i = 0; i < LANES; i++)
                p5_fin_reg[i] <= p4_fin_reg[i];
            for (int i = 0; i < NPM; i++)
                p5_pm_reg[i] <= pm_next[i];
        end
    end

    // ================= final stage =================
    always_comb
    begin
        ent[0][0] = sat_w(ONE_W - (fsum(p5_pm_reg[PM_YY], p5_pm_reg[PM_ZZ], '0, '0, 4'b0000) <<< 1));
        ent[0][1] = sat_w(fsum(p5_pm_reg[PM_XY], p5_pm_reg[PM_ZW], '0, '0, 4'b0000) <<< 1);
        ent[0][2] = sat_w(fsum(p5_pm_reg[PM_XZ], p5_pm_reg[PM_YW], '0, '0, 4'b0010) <<< 1);
        ent[1][0] = sat_w(fsum(p5_pm_reg[PM_XY], p5_pm_reg[PM_ZW], '0, '0, 4'b0010) <<< 1);
        ent[1][1] = sat_w(ONE_W - (fsum(p5_pm_reg[PM_XX], p5_pm_reg[PM_ZZ], '0, '0, 4'b0000) <<< 1));
        ent[1][2] = sat_w(fsum(p5_pm_reg[PM_YZ], p5_pm_reg[PM_XW], '0, '0, 4'b0000) <<< 1);
        ent[2][0] = sat_w(fsum(p5_pm_reg[PM_XZ], p5_pm_reg[PM_YW], '0, '0, 4'b0000) <<< 1);
        ent[2][1] = sat_w(fsum(p5_pm_reg[PM_YZ], p5_pm_reg[PM_XW], '0, '0, 4'b0010) <<< 1);
        ent[2][2] = sat_w(ONE_W - (fsum(p5_pm_reg[PM_XX], p5_pm_reg[PM_YY], '0, '0, 4'b0000) <<< 1));

        m_ovf = 1'b0;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < LANES; c++)
                rows_next[r][c] = '0;

        if (p5_op_reg == OP_MATRIX)
        begin
            for (int r = 0; r < ROWS - 1; r++)
                for (int c = 0; c < ROWS - 1; c++)
                    m_ovf = m_ovf | ent[r][c].ovf;
            if (p5_st_reg != ST_DZ)
            begin
                for (int r = 0; r < ROWS - 1; r++)
                    for (int c = 0; c < ROWS - 1; c++)
                        rows_next[r][c] = ent[r][c].val;
                rows_next[ROWS-1][LANES-1] = ONE_W[DW-1:0];
            end
            if (p5_st_reg == ST_DZ)
                f_st_next = ST_DZ;
            else if (p5_st_reg == ST_SAT || m_ovf)
                f_st_next = ST_SAT;
            else
                f_st_next = ST_OK;
        end
        else
        begin
            for (int c = 0; c < LANES; c++)
                rows_next[0][c] = p5_fin_reg[c];
            f_st_next = p5_st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            f_mat_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (f_valid_reg && f_mat_reg)
                cnt_reg <= cnt_reg + 2'd1;
            else
                cnt_reg <= '0;
            if (en)
            begin
                f_valid_reg <= p5_valid_reg;
                f_mat_reg   <= p5_valid_reg && (p5_op_reg == OP_MATRIX);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_st_reg <= f_st_next;
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < LANES; c++)
                    f_rows_reg[r][c] <= rows_next[r][c];
        end
    end

    // ================= result ports =================
    assign done             = f_valid_reg;
    assign result.res_real  = f_rows_reg[cnt_reg][0];
    assign result.res_i     = f_rows_reg[cnt_reg][1];
    assign result.res_j     = f_rows_reg[cnt_reg][2];
    assign result.res_k     = f_rows_reg[cnt_reg][3];
    assign result.row_index = cnt_reg;
    assign result.last      = !f_mat_reg || (cnt_reg == ROW_LAST);
    assign result.status    = f_st_reg;

endmodule

`default_nettype wire
